>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the quantizer RTL.
// KQ_ASSERT checks outside reset; KQ_ASSERT_ALWAYS checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KQ_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
`define KQ_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("%m: check failed");
`else
`define KQ_ASSERT(name, prop)
`define KQ_ASSERT_ALWAYS(name, prop)
`endif
`endif

>>> rtl/core/kqnt_pkg.sv
package kqnt_pkg;

	localparam int CHAN_W = 8;
	localparam int IDX_W  = 14;
	localparam int CL_W   = 3;
	localparam int NK_W   = 4;
	localparam int IT_W   = 4;
	localparam int PC_W   = 15;
	localparam int LAB_W  = 3;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_SEED = 2'd1;
	localparam logic [1:0] MODE_RUN  = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [1:0] REG_ITER_COUNT   = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

	localparam logic [NK_W-1:0] NUM_CLUSTERS_RST = 4'd2;
	localparam logic [IT_W-1:0] ITER_COUNT_RST   = 4'd10;
	localparam logic [PC_W-1:0] PIXEL_COUNT_RST  = 15'd16384;

	typedef struct packed {
		logic [1:0]        mode;
		logic [IDX_W-1:0]  pixel_index;
		logic [CL_W-1:0]   cluster_index;
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [LAB_W-1:0]  label;
		logic [CHAN_W-1:0] color_a;
		logic [CHAN_W-1:0] color_b;
		logic [CHAN_W-1:0] color_c;
	} out_item_t;

	typedef struct packed {
		logic [NK_W-1:0] num_clusters;
		logic [IT_W-1:0] iteration_count;
		logic [PC_W-1:0] pixel_count;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RUN_CLR,
		ST_RUN_RD,
		ST_RUN_LAT,
		ST_RUN_DIST,
		ST_RUN_ACC,
		ST_UPD,
		ST_DIV
	} kq_state_t;

endpackage

>>> rtl/core/kqnt_if.sv
interface kqnt_in_if import kqnt_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface kqnt_out_if import kqnt_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/kqnt_cfg.sv
module kqnt_cfg import kqnt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_clusters    <= NUM_CLUSTERS_RST;
			cfg_q.iteration_count <= ITER_COUNT_RST;
			cfg_q.pixel_count     <= PIXEL_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_NUM_CLUSTERS: cfg_q.num_clusters    <= pwdata[NK_W-1:0];
				REG_ITER_COUNT:   cfg_q.iteration_count <= pwdata[IT_W-1:0];
				REG_PIXEL_COUNT:  cfg_q.pixel_count     <= pwdata[PC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_CLUSTERS: prdata = APB_DW'(cfg_q.num_clusters);
			REG_ITER_COUNT:   prdata = APB_DW'(cfg_q.iteration_count);
			REG_PIXEL_COUNT:  prdata = APB_DW'(cfg_q.pixel_count);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/kqnt_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module kqnt_div import kqnt_pkg::*; #(
	parameter int DW = 31,
	parameter int VW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign done     = cnt_q == CNT_W'(1);
	assign quotient = {quo_q[DW-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
		end
	end

	`KQ_ASSERT(a_no_restart, busy |-> !start)
	`KQ_ASSERT(a_done_after_busy, done |-> $past(busy))
	`KQ_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !busy)

endmodule

>>> rtl/core/rgb_kmeans_color_quantizer_top.sv
// channel   dir  handshake              beat payload
// in_ch     in   valid/ready            mode, pixel_index, cluster_index, chan_a..c
// out_ch    out  valid/ready            status, label, color_a..c
// apb       in   psel/penable/pwrite    paddr 4*i, pwdata (pready tied high)
//
// Load and rejected items finish when accepted; seed and read finish from ST_FETCH (memory read).
// A run's time is set by the per-center distance step and the bit-serial mean
// divider (DIV_W = 8+NW+FRAC).
// Reset clears centers, accumulators and control; pixel and label memories hold
// garbage until written. A result waiting in the output register holds off the
// next item unless that result leaves in the same cycle.
`include "assert_macros.svh"

module rgb_kmeans_color_quantizer_top import kqnt_pkg::*; #(
	parameter int MAX_PIXELS   = 16384,
	parameter int MAX_CLUSTERS = 8,
	parameter int FRAC_BITS    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	kqnt_in_if.sink           in_ch,
	kqnt_out_if.source        out_ch
);

	localparam int AW  = $clog2(MAX_PIXELS);
	localparam int NW  = $clog2(MAX_PIXELS + 1);
	localparam int LW  = $clog2(MAX_CLUSTERS);
	localparam int KW  = $clog2(MAX_CLUSTERS + 1);
	localparam int CW  = CHAN_W + FRAC_BITS;
	localparam int SW  = CHAN_W + NW;
	localparam int DVW = SW + FRAC_BITS;
	localparam int DSW = 2 * CW + 2;
	localparam int EW  = (NW > PC_W) ? NW : PC_W;
	localparam int XW  = (NW > IDX_W) ? NW : IDX_W;
	localparam int QW  = (KW > NK_W) ? KW : NK_W;
	localparam int CKW = (KW > CL_W) ? KW : CL_W;

	cfg_t cfg;

	kqnt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Saturate configuration into the ranges the hardware holds.
	logic [NW-1:0] eff_n;
	logic [KW-1:0] eff_k;
	always_comb begin
		if (EW'(cfg.pixel_count) > EW'(MAX_PIXELS)) eff_n = NW'(MAX_PIXELS);
		else eff_n = NW'(cfg.pixel_count);
		if (QW'(cfg.num_clusters) < QW'(2)) eff_k = KW'(2);
		else if (QW'(cfg.num_clusters) > QW'(MAX_CLUSTERS)) eff_k = KW'(MAX_CLUSTERS);
		else eff_k = KW'(cfg.num_clusters);
	end

	kq_state_t state_q, state_d;

	logic            in_acc;
	logic            idx_ok, cl_ok;
	logic [1:0]      mode_q;
	logic [LW-1:0]   cl_q;
	logic [AW-1:0]   i_q;
	logic [KW-1:0]   j_q;
	logic [KW-1:0]   uj_q;
	logic [1:0]      uc_q;
	logic [IT_W-1:0] pass_q;
	logic [23:0]     px_q;
	logic            last_px, pass_last, upd_end;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign idx_ok  = XW'(in_ch.data.pixel_index) < XW'(eff_n);
	assign cl_ok   = CKW'(in_ch.data.cluster_index) < CKW'(eff_k);
	assign last_px = (NW'(i_q) + NW'(1)) == eff_n;
	assign pass_last = (pass_q + IT_W'(1)) == cfg.iteration_count;
	assign upd_end = uj_q == eff_k;

	// Pixel and label memories: one write, one registered read.
	logic [23:0]   pix_mem [MAX_PIXELS];
	logic [LW-1:0] lab_mem [MAX_PIXELS];
	logic [23:0]   pix_rd_q;
	logic [LW-1:0] lab_rd_q;
	logic [AW-1:0] pix_ra, in_addr;
	logic          pix_we, lab_we;
	logic [LW-1:0] best_q;

	assign in_addr = AW'(in_ch.data.pixel_index);
	assign pix_ra  = (state_q == ST_IDLE) ? in_addr : i_q;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[in_addr] <= {in_ch.data.chan_c, in_ch.data.chan_b, in_ch.data.chan_a};
		end
		pix_rd_q <= pix_mem[pix_ra];
	end

	always_ff @(posedge clk) begin
		if (lab_we) begin
			lab_mem[i_q] <= best_q;
		end
		lab_rd_q <= lab_mem[in_addr];
	end

	// Centers, accumulators and counts; each read through one address mux.
	logic [CW-1:0] cen_q [MAX_CLUSTERS][3];
	logic [SW-1:0] sum_q [MAX_CLUSTERS][3];
	logic [NW-1:0] cnt_q [MAX_CLUSTERS];
	logic [LW-1:0] cen_ra, acc_ra;
	logic [CW-1:0] cen_rd [3];
	logic [NW-1:0] cnt_rd;
	logic [SW-1:0] sum_rd;

	always_comb begin
		case (state_q)
			ST_FETCH: cen_ra = lab_rd_q;
			default:  cen_ra = j_q[LW-1:0];
		endcase
		acc_ra = (state_q == ST_RUN_ACC) ? best_q : uj_q[LW-1:0];
		for (int c = 0; c < 3; c++) cen_rd[c] = cen_q[cen_ra][c];
		cnt_rd = cnt_q[acc_ra];
		sum_rd = sum_q[acc_ra][uc_q];
	end

	// Distance step: squares registered, then summed and compared.
	logic              issue;
	logic              v_s1, last_s1;
	logic [LW-1:0]     j_s1;
	logic [2*CW-1:0]   sq_s1 [3];
	logic [CW-1:0]     pv [3];
	logic [CW-1:0]     dv [3];
	logic [2*CW-1:0]   sq [3];
	logic [DSW-1:0]    d_sum;
	logic [DSW-1:0]    best_d_q;

	assign issue = (state_q == ST_RUN_DIST) && (j_q < eff_k);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pv[c] = {px_q[8*c +: 8], FRAC_BITS'(0)};
			dv[c] = (pv[c] > cen_rd[c]) ? pv[c] - cen_rd[c] : cen_rd[c] - pv[c];
			sq[c] = (2*CW)'(dv[c]) * (2*CW)'(dv[c]);
		end
		d_sum = DSW'(sq_s1[0]) + DSW'(sq_s1[1]) + DSW'(sq_s1[2]);
	end

	// Mean divider.
	logic             div_start, div_busy, div_done;
	logic [DVW-1:0]   div_quo;

	kqnt_div #(
		.DW (DVW),
		.VW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_rd, FRAC_BITS'(0)}),
		.divisor  (cnt_rd),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_ch.data.mode)
						MODE_RUN:  state_d = (cfg.iteration_count == '0) ? ST_IDLE : ST_RUN_CLR;
						MODE_SEED: state_d = (idx_ok && cl_ok) ? ST_FETCH : ST_IDLE;
						MODE_READ: state_d = idx_ok ? ST_FETCH : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH:    state_d = ST_IDLE;
			ST_RUN_CLR:  state_d = (eff_n == '0) ? ST_UPD : ST_RUN_RD;
			ST_RUN_RD:   state_d = ST_RUN_LAT;
			ST_RUN_LAT:  state_d = ST_RUN_DIST;
			ST_RUN_DIST: state_d = (v_s1 && last_s1) ? ST_RUN_ACC : ST_RUN_DIST;
			ST_RUN_ACC:  state_d = last_px ? ST_UPD : ST_RUN_RD;
			ST_UPD: begin
				if (upd_end) state_d = pass_last ? ST_IDLE : ST_RUN_CLR;
				else if (cnt_rd != '0) state_d = ST_DIV;
			end
			ST_DIV:      state_d = div_done ? ST_UPD : ST_DIV;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	logic      fin;
	out_item_t fin_item;
	logic      out_v_q;
	out_item_t out_q;

	// Take a beat only when idle and the output register is free or draining.
	assign in_ch.ready = (state_q == ST_IDLE) && (!out_v_q || out_ch.ready);

	always_comb begin
		fin       = 1'b0;
		fin_item  = '0;
		pix_we    = 1'b0;
		lab_we    = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_ch.data.mode)
						MODE_LOAD: begin
							fin = 1'b1;
							fin_item.status = !idx_ok;
							pix_we = idx_ok;
						end
						MODE_SEED: begin
							fin = !(idx_ok && cl_ok);
							fin_item.status = 1'b1;
						end
						MODE_READ: begin
							fin = !idx_ok;
							fin_item.status = 1'b1;
						end
						default: fin = (cfg.iteration_count == '0);
					endcase
				end
			end
			ST_FETCH: begin
				fin = 1'b1;
				if (mode_q == MODE_READ) begin
					fin_item.label   = LAB_W'(lab_rd_q);
					fin_item.color_a = cen_rd[0][CW-1:FRAC_BITS];
					fin_item.color_b = cen_rd[1][CW-1:FRAC_BITS];
					fin_item.color_c = cen_rd[2][CW-1:FRAC_BITS];
				end
			end
			ST_RUN_ACC: lab_we = 1'b1;
			ST_UPD: begin
				fin       = upd_end && pass_last;
				div_start = !upd_end && (cnt_rd != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (fin) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) out_q <= fin_item;
		if (in_acc) begin
			mode_q <= in_ch.data.mode;
			cl_q   <= LW'(in_ch.data.cluster_index);
		end
		if (state_q == ST_RUN_LAT) px_q <= pix_rd_q;
		// Squares of the center under test.
		last_s1 <= (j_q == KW'(eff_k - KW'(1)));
		j_s1    <= j_q[LW-1:0];
		for (int c = 0; c < 3; c++) sq_s1[c] <= sq[c];
		// Keep the nearest center; lowest index wins ties.
		if (v_s1 && (j_s1 == '0 || d_sum < best_d_q)) begin
			best_d_q <= d_sum;
			best_q   <= j_s1;
		end
	end

	// Sequencer counters, centers and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			uj_q   <= '0;
			uc_q   <= '0;
			pass_q <= '0;
			for (int k = 0; k < MAX_CLUSTERS; k++) begin
				cnt_q[k] <= '0;
				for (int c = 0; c < 3; c++) begin
					cen_q[k][c] <= '0;
					sum_q[k][c] <= '0;
				end
			end
		end else begin
			if (in_acc) pass_q <= '0;
			// Seed a center from the fetched pixel.
			if (state_q == ST_FETCH && mode_q == MODE_SEED) begin
				for (int c = 0; c < 3; c++)
					cen_q[cl_q][c] <= {pix_rd_q[8*c +: 8], FRAC_BITS'(0)};
			end
			if (state_q == ST_RUN_CLR) begin
				i_q  <= '0;
				uj_q <= '0;
				uc_q <= '0;
				for (int k = 0; k < MAX_CLUSTERS; k++) begin
					cnt_q[k] <= '0;
					for (int c = 0; c < 3; c++) sum_q[k][c] <= '0;
				end
			end
			if (state_q == ST_RUN_LAT) j_q <= '0;
			if (issue) j_q <= j_q + KW'(1);
			if (state_q == ST_RUN_ACC) begin
				cnt_q[acc_ra] <= cnt_rd + NW'(1);
				for (int c = 0; c < 3; c++)
					sum_q[acc_ra][c] <= sum_q[acc_ra][c] + SW'(px_q[8*c +: 8]);
				i_q <= i_q + AW'(1);
			end
			// Write one mean channel, then advance channel and cluster.
			if ((state_q == ST_UPD && !upd_end && cnt_rd == '0) ||
					(state_q == ST_DIV && div_done)) begin
				cen_q[uj_q[LW-1:0]][uc_q] <= (state_q == ST_DIV) ? CW'(div_quo) : '0;
				if (uc_q == 2'd2) begin
					uc_q <= '0;
					uj_q <= uj_q + KW'(1);
				end else begin
					uc_q <= uc_q + 2'd1;
				end
			end
			if (state_q == ST_UPD && upd_end) pass_q <= pass_q + IT_W'(1);
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	`KQ_ASSERT(a_busy_no_result, (state_q != ST_IDLE) |-> !out_v_q)
	`KQ_ASSERT(a_div_only_in_update, div_start |-> (state_q == ST_UPD) && !div_busy)
	`KQ_ASSERT(a_label_in_range, lab_we |-> (KW'(best_q) < eff_k))
	`KQ_ASSERT_ALWAYS(a_rst_no_beat, !arst_n |-> !out_v_q)

endmodule
